@@ hw/rtl/particle_cube_fit_and_normalize_core_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the particle cube fit and normalize core
// Each macro expands to one labeled concurrent assertion on i_clk/i_rst_n.
// ---------------------------------------------------------------------------
`ifndef PARTICLE_CUBE_FIT_AND_NORMALIZE_CORE_DEFINES_SVH
`define PARTICLE_CUBE_FIT_AND_NORMALIZE_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define PCF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define PCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/pcf_pkg.sv @@
// ---------------------------------------------------------------------------
// pcf_pkg
// Shared constants, types and helpers of the particle cube fit core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcf_pkg;

    localparam int POS_W       = 32;
    localparam int FRAC_BITS   = 16;
    localparam int SHRINK_W    = 17;
    localparam int CFG_IDX_W   = 3;
    localparam int RECIP_STEPS = FRAC_BITS + POS_W;
    localparam int RECIP_CNT_W = $clog2(RECIP_STEPS);

    localparam logic [SHRINK_W-1:0] SHRINK_ONE = 17'd65536;
    localparam logic [15:0]         HALF_Q16   = 16'd32768;
    localparam logic [15:0]         FACTOR_051 = 16'd33423;

    // A nonzero side at or below this saturates the reciprocal
    localparam logic [POS_W-2:0] RECIP_SAT_SIDE = (POS_W-1)'(1) << (FRAC_BITS - 1);
    localparam logic [POS_W-2:0] SIDE_MAX       = '1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHRINK     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LOW_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LOW_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LOW_Z  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HIGH_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HIGH_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HIGH_Z = 3'd6;

    typedef enum logic [1:0] {
        K_ACCUM  = 2'd0,
        K_FINISH = 2'd1,
        K_NORM   = 2'd2,
        K_UNUSED = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        O_LOW  = 2'd0,
        O_HIGH = 2'd1,
        O_NORM = 2'd2
    } t_out_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIN_SPAN,
        S_FIN_MUL,
        S_FIN_E,
        S_FIN_H,
        S_CORNER,
        S_EMIT_LO,
        S_EMIT_HI,
        S_RECIP,
        S_NORM_DIFF,
        S_NORM_MUL,
        S_NORM_OUT
    } t_back_state;

    typedef struct packed {
        t_kind                     kind;
        logic [2:0][POS_W-1:0]     pos;
    } t_item;

    typedef struct packed {
        logic             start;
        logic [POS_W-2:0] side;
    } t_recip_req;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] recip;
    } t_recip_rsp;

    // Clamp a wide signed value into the position range
    function automatic logic [POS_W-1:0] pcf_sat(input logic signed [POS_W+2:0] v);
        logic signed [POS_W+2:0] hi;
        logic signed [POS_W+2:0] lo;
        hi = (POS_W+3)'({1'b0, {(POS_W-1){1'b1}}});
        lo = -hi - (POS_W+3)'(1);
        if (v > hi) begin
            return {1'b0, {(POS_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(POS_W-1){1'b0}}};
        end
        return v[POS_W-1:0];
    endfunction

endpackage

@@ hw/rtl/pcf_front.sv @@
// ---------------------------------------------------------------------------
// pcf_front
// Input side: accepts items, drops unused kinds, and queues the rest in a
// two-entry queue for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "particle_cube_fit_and_normalize_core_defines.svh"

module pcf_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_kind,
    input  logic [pcf_pkg::POS_W-1:0] i_pos_x,
    input  logic [pcf_pkg::POS_W-1:0] i_pos_y,
    input  logic [pcf_pkg::POS_W-1:0] i_pos_z,
    output logic                      o_item_valid,
    output pcf_pkg::t_item            o_item,
    input  logic                      i_pop
);
    import pcf_pkg::*;

    t_item       r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;
    logic        w_push;
    t_item       w_in;

    assign o_ready      = (r_count != 2'd2);
    assign w_in.kind    = t_kind'(i_kind);
    assign w_in.pos     = {i_pos_z, i_pos_y, i_pos_x};
    // unused kind is taken and discarded
    assign w_push       = i_valid && o_ready && (w_in.kind != K_UNUSED);
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_mem[r_rptr];

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (w_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!w_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_in;
        end
    end

    `PCF_ASSERT_SAME(a_count_range, 1'b1, r_count != 2'd3, "queue count out of range")
    `PCF_ASSERT_SAME(a_pop_nonempty, i_pop, r_count != 2'd0, "pop from empty queue")
    `PCF_ASSERT_SAME(a_full_not_ready, r_count == 2'd2, !o_ready, "ready while queue full")

endmodule

@@ hw/rtl/pcf_recip.sv @@
// ---------------------------------------------------------------------------
// pcf_recip
// Side reciprocal: restoring division of 2^(FRAC_BITS+31) by the side, one
// quotient bit per cycle, saturated to 32 bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcf_recip (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pcf_pkg::t_recip_req i_req,
    output pcf_pkg::t_recip_rsp o_rsp
);
    import pcf_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [RECIP_CNT_W-1:0] r_cnt;
    logic [POS_W-2:0]       r_side;
    logic [POS_W-2:0]       r_rem;
    logic [POS_W-1:0]       r_quo;
    logic [POS_W-1:0]       w_trial;
    logic                   w_ge;

    // dividend is a single one at its top bit
    assign w_trial = {r_rem, (r_cnt == '0)};
    assign w_ge    = (w_trial >= {1'b0, r_side});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == RECIP_CNT_W'(RECIP_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + RECIP_CNT_W'(1);
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_side <= i_req.side;
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_trial[POS_W-2:0] - r_side) : w_trial[POS_W-2:0];
            r_quo <= {r_quo[POS_W-2:0], w_ge};
        end
    end

    // empty side gives zero, small side saturates
    always_comb begin
        o_rsp.done = r_done;
        if (r_side == '0) begin
            o_rsp.recip = '0;
        end else if (r_side <= RECIP_SAT_SIDE) begin
            o_rsp.recip = '1;
        end else begin
            o_rsp.recip = r_quo;
        end
    end

endmodule

@@ hw/rtl/pcf_back.sv @@
// ---------------------------------------------------------------------------
// pcf_back
// Execution side: bound tracking, cube fit on finish, normalization, the
// configuration registers and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "particle_cube_fit_and_normalize_core_defines.svh"

module pcf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    input  pcf_pkg::t_item                i_item,
    output logic                          o_pop,
    input  logic                          i_cfg_wen,
    input  logic [pcf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pcf_pkg::POS_W-1:0]     i_cfg_data,
    output pcf_pkg::t_recip_req           o_recip_req,
    input  pcf_pkg::t_recip_rsp           i_recip_rsp,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_out_kind,
    output logic [pcf_pkg::POS_W-1:0]     o_out_x,
    output logic [pcf_pkg::POS_W-1:0]     o_out_y,
    output logic [pcf_pkg::POS_W-1:0]     o_out_z,
    output logic                          o_out_last
);
    import pcf_pkg::*;

    t_back_state r_state, n_state;

    // configuration
    logic [SHRINK_W-1:0] r_shrink;
    logic [POS_W-1:0]    r_box_lo [3];
    logic [POS_W-1:0]    r_box_hi [3];

    // architectural state
    logic [POS_W-1:0]    r_min [3];
    logic [POS_W-1:0]    r_max [3];
    logic                r_seen;
    logic [POS_W-1:0]    r_cube_low [3];
    logic [POS_W-2:0]    r_side;
    logic [POS_W-1:0]    r_recip;

    // working registers
    logic [2:0][POS_W-1:0]     r_pt;
    logic signed [POS_W:0]     r_span [3];
    logic signed [POS_W:0]     r_b;
    logic [SHRINK_W-1:0]       r_s;
    logic                      r_use_box;
    logic [POS_W+SHRINK_W-1:0] r_p1;
    logic [POS_W+SHRINK_W-1:0] r_p2;
    logic [POS_W-1:0]          r_e;
    logic [POS_W-1:0]          r_h;
    logic [POS_W-1:0]          r_lo [3];
    logic [POS_W-1:0]          r_hi [3];
    logic [POS_W-1:0]          r_nlo [3];
    logic                      r_nhi [3];
    logic                      r_nneg [3];
    logic [2*POS_W-1:0]        r_nprod [3];

    // output register
    logic                r_ov;
    t_out_kind           r_okind;
    logic [POS_W-1:0]    r_ox, r_oy, r_oz;
    logic                r_olast;

    logic                w_out_free;
    logic                w_take;
    logic                w_ld_lo, w_ld_hi, w_ld_norm;

    // corner and side datapath
    logic signed [POS_W+2:0] w_c2 [3];
    logic signed [POS_W+2:0] w_two_h;
    logic [POS_W-1:0]        w_lo [3];
    logic [POS_W-1:0]        w_hi [3];
    logic signed [POS_W:0]   w_side_d;
    logic [POS_W-2:0]        w_side;

    assign w_out_free = !r_ov || i_ready;
    assign w_take     = o_pop && (i_item.kind == K_ACCUM);

    // state sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_pop             = 1'b0;
        w_ld_lo           = 1'b0;
        w_ld_hi           = 1'b0;
        w_ld_norm         = 1'b0;
        o_recip_req.start = 1'b0;
        o_recip_req.side  = r_side;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_pop = 1'b1;
                    case (i_item.kind)
                        K_FINISH: n_state = S_FIN_SPAN;
                        K_NORM:   n_state = S_NORM_DIFF;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_FIN_SPAN: n_state = S_FIN_MUL;
            S_FIN_MUL:  n_state = S_FIN_E;
            S_FIN_E:    n_state = S_FIN_H;
            S_FIN_H:    n_state = S_CORNER;
            S_CORNER:   n_state = S_EMIT_LO;
            S_EMIT_LO: begin
                if (w_out_free) begin
                    w_ld_lo = 1'b1;
                    n_state = S_EMIT_HI;
                end
            end
            S_EMIT_HI: begin
                if (w_out_free) begin
                    w_ld_hi           = 1'b1;
                    o_recip_req.start = 1'b1;
                    n_state           = S_RECIP;
                end
            end
            S_RECIP: begin
                if (i_recip_rsp.done) begin
                    n_state = S_IDLE;
                end
            end
            S_NORM_DIFF: n_state = S_NORM_MUL;
            S_NORM_MUL:  n_state = S_NORM_OUT;
            S_NORM_OUT: begin
                if (w_out_free) begin
                    w_ld_norm = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // configuration, bounds and cube state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shrink <= '0;
            for (int k = 0; k < 3; k++) begin
                r_box_lo[k]   <= '0;
                r_box_hi[k]   <= POS_W'(1) << FRAC_BITS;
                r_min[k]      <= {1'b0, {(POS_W-1){1'b1}}};
                r_max[k]      <= {1'b1, {(POS_W-1){1'b0}}};
                r_cube_low[k] <= '0;
            end
            r_seen  <= 1'b0;
            r_side  <= (POS_W-1)'(1) << FRAC_BITS;
            r_recip <= POS_W'(1) << (POS_W - 1);
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    CFG_SHRINK:     r_shrink    <= i_cfg_data[SHRINK_W-1:0];
                    CFG_BOX_LOW_X:  r_box_lo[0] <= i_cfg_data;
                    CFG_BOX_LOW_Y:  r_box_lo[1] <= i_cfg_data;
                    CFG_BOX_LOW_Z:  r_box_lo[2] <= i_cfg_data;
                    CFG_BOX_HIGH_X: r_box_hi[0] <= i_cfg_data;
                    CFG_BOX_HIGH_Y: r_box_hi[1] <= i_cfg_data;
                    CFG_BOX_HIGH_Z: r_box_hi[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            // accumulate a point
            if (w_take) begin
                for (int k = 0; k < 3; k++) begin
                    if ($signed(i_item.pos[k]) < $signed(r_min[k])) begin
                        r_min[k] <= i_item.pos[k];
                    end
                    if ($signed(i_item.pos[k]) > $signed(r_max[k])) begin
                        r_max[k] <= i_item.pos[k];
                    end
                end
                r_seen <= 1'b1;
            end
            // cube fixed: keep low corner, clear bounds
            if (r_state == S_CORNER) begin
                for (int k = 0; k < 3; k++) begin
                    r_cube_low[k] <= r_use_box ? r_box_lo[k] : w_lo[k];
                    r_min[k]      <= {1'b0, {(POS_W-1){1'b1}}};
                    r_max[k]      <= {1'b1, {(POS_W-1){1'b0}}};
                end
                r_seen <= 1'b0;
            end
            if (w_ld_lo) begin
                r_side <= w_side;
            end
            if ((r_state == S_RECIP) && i_recip_rsp.done) begin
                r_recip <= i_recip_rsp.recip;
            end
        end
    end

    // corner arithmetic: floor((min + max -/+ 2h) / 2), saturated
    always_comb begin
        w_two_h = $signed({2'b00, r_h, 1'b0});
        for (int k = 0; k < 3; k++) begin
            w_c2[k] = $signed({{3{r_min[k][POS_W-1]}}, r_min[k]})
                    + $signed({{3{r_max[k][POS_W-1]}}, r_max[k]});
            w_lo[k] = pcf_sat((w_c2[k] - w_two_h) >>> 1);
            w_hi[k] = pcf_sat((w_c2[k] + w_two_h) >>> 1);
        end
    end

    // side of the emitted cube, clamped to [0, max]
    always_comb begin
        w_side_d = $signed({r_hi[0][POS_W-1], r_hi[0]}) - $signed({r_lo[0][POS_W-1], r_lo[0]});
        if (w_side_d[POS_W]) begin
            w_side = '0;
        end else if (w_side_d[POS_W-1]) begin
            w_side = SIDE_MAX;
        end else begin
            w_side = w_side_d[POS_W-2:0];
        end
    end

    // cube fit datapath
    logic signed [POS_W:0]       w_d;
    logic [POS_W+SHRINK_W:0]     w_esum;
    logic [POS_W+16-1:0]         w_hsum;
    logic signed [POS_W:0]       w_diff [3];

    always_comb begin
        w_d = r_span[0];
        if (r_span[1] > w_d) begin
            w_d = r_span[1];
        end
        if (r_span[2] > w_d) begin
            w_d = r_span[2];
        end
        w_esum = {1'b0, r_p1} + {1'b0, r_p2} + (POS_W+SHRINK_W+1)'(HALF_Q16);
        w_hsum = r_e * FACTOR_051 + (POS_W+16)'(HALF_Q16);
        for (int k = 0; k < 3; k++) begin
            w_diff[k] = $signed({r_pt[k][POS_W-1], r_pt[k]})
                      - $signed({r_cube_low[k][POS_W-1], r_cube_low[k]});
        end
    end

    // normalize output: |d| * recip / 2^31, signed, saturated
    logic [POS_W+1:0] w_q [3];
    logic [POS_W-1:0] w_norm [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_q[k] = {1'b0, r_nprod[k][2*POS_W-1:POS_W-1]}
                   + (r_nhi[k] ? {1'b0, r_recip, 1'b0} : '0);
            if (w_q[k] > (POS_W+2)'(SIDE_MAX)) begin
                w_norm[k] = r_nneg[k] ? {1'b1, {(POS_W-1){1'b0}}}
                                      : {1'b0, {(POS_W-1){1'b1}}};
            end else begin
                w_norm[k] = r_nneg[k] ? (POS_W'(0) - w_q[k][POS_W-1:0]) : w_q[k][POS_W-1:0];
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_pt <= i_item.pos;
            end
            S_FIN_SPAN: begin
                for (int k = 0; k < 3; k++) begin
                    r_span[k] <= $signed({r_max[k][POS_W-1], r_max[k]})
                               - $signed({r_min[k][POS_W-1], r_min[k]});
                end
                r_b <= $signed({r_box_hi[0][POS_W-1], r_box_hi[0]})
                     - $signed({r_box_lo[0][POS_W-1], r_box_lo[0]});
                r_s <= (r_shrink > SHRINK_ONE) ? SHRINK_ONE : r_shrink;
            end
            S_FIN_MUL: begin
                r_use_box <= (r_s == '0) || !r_seen || (w_d >= r_b);
                r_p1      <= w_d[POS_W-1:0] * r_s;
                r_p2      <= r_b[POS_W-1:0] * (SHRINK_ONE - r_s);
            end
            S_FIN_E: begin
                r_e <= w_esum[POS_W+15:16];
            end
            S_FIN_H: begin
                r_h <= w_hsum[POS_W+15:16];
            end
            S_CORNER: begin
                for (int k = 0; k < 3; k++) begin
                    r_lo[k] <= r_use_box ? r_box_lo[k] : w_lo[k];
                    r_hi[k] <= r_use_box ? r_box_hi[k] : w_hi[k];
                end
            end
            S_NORM_DIFF: begin
                for (int k = 0; k < 3; k++) begin
                    r_nneg[k] <= w_diff[k][POS_W];
                    {r_nhi[k], r_nlo[k]} <= w_diff[k][POS_W] ? (POS_W+1)'(-w_diff[k])
                                                             : w_diff[k];
                end
            end
            S_NORM_MUL: begin
                for (int k = 0; k < 3; k++) begin
                    r_nprod[k] <= r_nlo[k] * r_recip;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_ld_lo || w_ld_hi || w_ld_norm) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_lo) begin
            r_okind <= O_LOW;
            r_ox    <= r_lo[0];
            r_oy    <= r_lo[1];
            r_oz    <= r_lo[2];
            r_olast <= 1'b0;
        end else if (w_ld_hi) begin
            r_okind <= O_HIGH;
            r_ox    <= r_hi[0];
            r_oy    <= r_hi[1];
            r_oz    <= r_hi[2];
            r_olast <= 1'b1;
        end else if (w_ld_norm) begin
            r_okind <= O_NORM;
            r_ox    <= w_norm[0];
            r_oy    <= w_norm[1];
            r_oz    <= w_norm[2];
            r_olast <= 1'b1;
        end
    end

    assign o_valid    = r_ov;
    assign o_out_kind = r_okind;
    assign o_out_x    = r_ox;
    assign o_out_y    = r_oy;
    assign o_out_z    = r_oz;
    assign o_out_last = r_olast;

    `PCF_ASSERT_SAME(a_pop_idle, o_pop, r_state == S_IDLE, "item taken while busy")
    `PCF_ASSERT_NEXT(a_bounds_clear, r_state == S_CORNER, !r_seen, "bounds not cleared")
    `PCF_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid, "result dropped while stalled")

endmodule

@@ hw/rtl/particle_cube_fit_and_normalize_core.sv @@
// ---------------------------------------------------------------------------
// particle_cube_fit_and_normalize_core
// Bounding cube fit of Q16.16 particle positions with point normalization.
// ---------------------------------------------------------------------------
// Items enter a two-entry queue and are executed one at a time by the back
// end. An accumulate item is popped from the head of the queue and updates
// the bounds straight from the idle state. A normalize item steps through
// difference, multiply by the side reciprocal, and scale and saturate, plus
// any wait on the output register. A finish item runs its fit sequence,
// hands out its two corners, then waits on the bit-serial reciprocal divider
// (48 quotient bits, one per cycle for a 2^47 dividend) before the next item
// starts. The result register decouples the output, so the queue keeps
// taking items while it has room and a result waits to be taken.
`timescale 1ns / 1ps

module particle_cube_fit_and_normalize_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_kind,
    input  logic [pcf_pkg::POS_W-1:0]     i_pos_x,
    input  logic [pcf_pkg::POS_W-1:0]     i_pos_y,
    input  logic [pcf_pkg::POS_W-1:0]     i_pos_z,
    input  logic                          i_cfg_wen,
    input  logic [pcf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pcf_pkg::POS_W-1:0]     i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_out_kind,
    output logic [pcf_pkg::POS_W-1:0]     o_out_x,
    output logic [pcf_pkg::POS_W-1:0]     o_out_y,
    output logic [pcf_pkg::POS_W-1:0]     o_out_z,
    output logic                          o_out_last
);
    import pcf_pkg::*;

    logic       w_item_valid;
    t_item      w_item;
    logic       w_pop;
    t_recip_req w_recip_req;
    t_recip_rsp w_recip_rsp;

    pcf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_pop        (w_pop)
    );

    pcf_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_recip_req),
        .o_rsp   (w_recip_rsp)
    );

    pcf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_pop        (w_pop),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_recip_req  (w_recip_req),
        .i_recip_rsp  (w_recip_rsp),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_kind   (o_out_kind),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z),
        .o_out_last   (o_out_last)
    );

endmodule
